// ----- hw/rtl/wialu_pkg.sv -----
`default_nettype none
package wialu_pkg;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned TOTAL_W = 256;
    localparam int unsigned CNT_W   = 9;

    typedef logic [2:0] t_mode;
    localparam t_mode MODE_ADD = 3'd0;
    localparam t_mode MODE_SUB = 3'd1;
    localparam t_mode MODE_NEG = 3'd2;
    localparam t_mode MODE_MUL = 3'd3;
    localparam t_mode MODE_SHL = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } t_state;
endpackage
`default_nettype wire

// ----- hw/rtl/wialu_core.sv -----
`default_nettype none
// Serial engine. Add, subtract and negate run a one-bit ripple add with a
// carry register, one bit per cycle over all 256 bits. Shift moves the word
// left one bit per cycle until the distance counts down to zero.
// Multiply walks the bits of a from the bottom. For each bit it makes one
// pass over eight 32-bit digits: a set bit adds the shifted copy of b into
// the product one digit per cycle, and a clear bit just rotates the product.
// At the end of each pass b moves left by one.
module wialu_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire wialu_pkg::t_mode            i_mode,
    input  wire logic [255:0]                i_a,
    input  wire logic [255:0]                i_b,
    input  wire logic [8:0]                  i_amount,
    output logic                             o_done,
    output logic [255:0]                     o_result
);
    import wialu_pkg::*;

    logic [255:0] r_x, n_x;      // first operand, shifts out LSB first
    logic [255:0] r_y, n_y;      // second operand / multiplicand
    logic [255:0] r_acc, n_acc;  // result shift register
    logic         r_c, n_c;
    logic [8:0]   r_cnt, n_cnt;
    logic [2:0]   r_dig, n_dig;
    logic         r_busy, n_busy;
    t_mode        r_mode, n_mode;
    logic         sum_bit, cout;
    logic [32:0]  dig_sum;

    // One-bit full adder for the serial modes.
    always_comb begin
        logic xb, yb;
        xb = r_x[0];
        yb = r_y[0];
        if (r_mode == MODE_SUB) yb = ~yb;
        if (r_mode == MODE_NEG) begin
            xb = ~r_x[0];
            yb = 1'b0;
        end
        sum_bit = xb ^ yb ^ r_c;
        cout    = (xb & yb) | (r_c & (xb ^ yb));
    end

    // One 32-bit digit of the multiply accumulation.
    assign dig_sum = {1'b0, r_acc[31:0]} + {1'b0, r_y[31:0]} + {32'd0, r_c};

    always_comb begin
        n_x = r_x; n_y = r_y; n_acc = r_acc; n_c = r_c;
        n_cnt = r_cnt; n_dig = r_dig; n_busy = r_busy; n_mode = r_mode;
        o_done = 1'b0;
        if (i_start) begin
            n_x = i_a; n_y = i_b; n_acc = '0; n_mode = i_mode;
            n_busy = 1'b1; n_cnt = '0; n_dig = '0;
            n_c = (i_mode == MODE_SUB || i_mode == MODE_NEG);
            if (i_mode == MODE_SHL) begin
                n_acc = i_a;
                n_cnt = i_amount;
                // A distance of 256 or more clears every bit at once.
                if (i_amount[8]) begin
                    n_acc = '0;
                    n_cnt = '0;
                end
            end
        end else if (r_busy) begin
            case (r_mode)
                MODE_ADD, MODE_SUB, MODE_NEG: begin
                    n_acc = {sum_bit, r_acc[255:1]};
                    n_x = r_x >> 1; n_y = r_y >> 1; n_c = cout;
                    n_cnt = r_cnt + 9'd1;
                    if (r_cnt == 9'd255) n_busy = 1'b0;
                end
                MODE_SHL: begin
                    // r_cnt counts down the shift distance.
                    if (r_cnt == '0) n_busy = 1'b0;
                    else begin
                        n_acc = r_acc << 1;
                        n_cnt = r_cnt - 9'd1;
                    end
                end
                MODE_MUL: begin
                    // r_acc holds the running product, r_y the shifted b.
                    if (r_x[0]) begin
                        n_acc = {dig_sum[31:0], r_acc[255:32]};
                        n_c   = dig_sum[32];
                    end else begin
                        n_acc = {r_acc[31:0], r_acc[255:32]};
                    end
                    n_y = {r_y[31:0], r_y[255:32]};
                    n_dig = r_dig + 3'd1;
                    if (r_dig == 3'd7) begin
                        // The carry out of the top digit falls off the width.
                        n_c = 1'b0;
                        n_y = {r_y[30:0], r_y[255:32], 1'b0};
                        n_x = r_x >> 1;
                        n_cnt = r_cnt + 9'd1;
                        if (r_cnt == 9'd255) n_busy = 1'b0;
                    end
                end
                default: begin
                    n_acc = '0;
                    n_busy = 1'b0;
                end
            endcase
            if (n_busy == 1'b0) o_done = 1'b1;
        end
    end

    assign o_result = r_acc;

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_acc <= n_acc; r_c <= n_c;
        r_cnt <= n_cnt; r_dig <= n_dig; r_mode <= n_mode;
        if (!i_rst_n) r_busy <= 1'b0;
        else          r_busy <= n_busy;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/wide_integer_alu_256.sv -----
// Steps: add, subtract and negate step once per bit over all 256 bits; multiply
// makes eight digit steps for each of the 256 bits of a; shift makes one step per
// bit of distance, or finishes at once for a distance of 256 or more.
// Throughput: one request at a time; the next is accepted in the cycle after
// the result is taken at the earliest.
// Reset: synchronous, active-low i_rst_n clears the control state only.
`default_nettype none
module wide_integer_alu_256 (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire wialu_pkg::t_mode     i_mode,
    input  wire logic [63:0]          i_a_word0,
    input  wire logic [63:0]          i_a_word1,
    input  wire logic [63:0]          i_a_word2,
    input  wire logic [63:0]          i_a_word3,
    input  wire logic [63:0]          i_b_word0,
    input  wire logic [63:0]          i_b_word1,
    input  wire logic [63:0]          i_b_word2,
    input  wire logic [63:0]          i_b_word3,
    input  wire logic [8:0]           i_shift_amount,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [63:0]               o_result_word0,
    output logic [63:0]               o_result_word1,
    output logic [63:0]               o_result_word2,
    output logic [63:0]               o_result_word3
);
    import wialu_pkg::*;

    t_state r_state, n_state;
    logic   start, done;
    logic [255:0] core_result;

    // A request is taken only when the engine and output are both free.
    // Unused mode codes give zero; the engine treats them as a single-step clear.
    assign o_ready = (r_state == ST_IDLE);
    assign start   = i_valid && o_ready;

    wialu_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_mode   (i_mode),
        .i_a      ({i_a_word3, i_a_word2, i_a_word1, i_a_word0}),
        .i_b      ({i_b_word3, i_b_word2, i_b_word1, i_b_word0}),
        .i_amount (i_shift_amount),
        .o_done   (done),
        .o_result (core_result)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (start) n_state = ST_RUN;
            ST_RUN:  if (done)  n_state = ST_OUT;
            ST_OUT:  if (i_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // The engine writes its last step on the edge that leaves ST_RUN and then
    // holds its registers until the next start, so the result is read from
    // it directly while the output waits.
    assign o_valid = (r_state == ST_OUT);
    assign o_result_word0 = core_result[63:0];
    assign o_result_word1 = core_result[127:64];
    assign o_result_word2 = core_result[191:128];
    assign o_result_word3 = core_result[255:192];
endmodule
`default_nettype wire

// ----- bench/tb_wide_integer_alu_256.sv -----
`timescale 1ns / 1ps

// Scoreboard for the 256-bit ALU: it predicts the result of each accepted
// request and compares each returned result against the oldest prediction.
class wialu_scoreboard;
    logic [255:0] pending_results[$];
    int unsigned  error_count;
    int unsigned  checked_count;

    function new();
        error_count   = 0;
        checked_count = 0;
    endfunction

    // Word-wise add with an explicit carry chain between the 64-bit words.
    static function logic [255:0] add256(logic [255:0] x, logic [255:0] y);
        logic [255:0] sum;
        logic [64:0]  partial;
        logic         carry;
        carry = 1'b0;
        for (int w = 0; w < 4; w++) begin
            partial = {1'b0, x[w*64 +: 64]} + {1'b0, y[w*64 +: 64]} + carry;
            sum[w*64 +: 64] = partial[63:0];
            carry = partial[64];
        end
        return sum;
    endfunction

    static function logic [255:0] shift_left256(logic [255:0] x, int unsigned amount);
        if (amount >= 256) return '0;
        return x << amount;
    endfunction

    static function logic [255:0] predict_result(wialu_pkg::t_mode mode, logic [255:0] a,
                                                 logic [255:0] b, logic [8:0] amount);
        logic [255:0] acc;
        acc = '0;
        case (mode)
            wialu_pkg::MODE_ADD: acc = add256(a, b);
            wialu_pkg::MODE_SUB: acc = add256(a, add256(~b, 256'd1));
            wialu_pkg::MODE_NEG: acc = add256(~a, 256'd1);
            wialu_pkg::MODE_MUL: begin
                for (int n = 0; n < 256; n++) begin
                    if (a[n]) acc = add256(acc, shift_left256(b, n));
                end
            end
            wialu_pkg::MODE_SHL: acc = shift_left256(a, amount);
            default: acc = '0;
        endcase
        return acc;
    endfunction

    function void note_request(wialu_pkg::t_mode mode, logic [255:0] a, logic [255:0] b,
                               logic [8:0] amount);
        pending_results.push_back(predict_result(mode, a, b, amount));
    endfunction

    task report_mismatch(string what);
        $display("MISMATCH: %s", what);
        error_count++;
    endtask

    task check_result(logic [255:0] got);
        logic [255:0] want;
        checked_count++;
        if (pending_results.size() == 0) begin
            report_mismatch("result arrived with no request outstanding");
            return;
        end
        want = pending_results.pop_front();
        for (int w = 0; w < 4; w++) begin
            if (got[w*64 +: 64] !== want[w*64 +: 64])
                report_mismatch($sformatf("result_word%0d got %h want %h", w,
                                          got[w*64 +: 64], want[w*64 +: 64]));
        end
    endtask
endclass

module tb_wide_integer_alu_256;
    import wialu_pkg::*;

    // The slowest request is a multiply; the watchdog allows far more than a
    // multiply plus the longest receiver stall.
    localparam int unsigned IDLE_LIMIT    = 20000;
    localparam int unsigned RANDOM_ITEMS  = 1700;
    localparam int unsigned DRAIN_CYCLES  = 600;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_mode       i_mode;
    logic [63:0] i_a_word0, i_a_word1, i_a_word2, i_a_word3;
    logic [63:0] i_b_word0, i_b_word1, i_b_word2, i_b_word3;
    logic [8:0]  i_shift_amount;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_result_word0, o_result_word1, o_result_word2, o_result_word3;

    wialu_scoreboard alu_board;
    int unsigned     idle_cycles;
    int unsigned     requests_sent;
    bit              stimulus_done;
    bit              stall_enable;

    wide_integer_alu_256 dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode),
        .i_a_word0(i_a_word0), .i_a_word1(i_a_word1),
        .i_a_word2(i_a_word2), .i_a_word3(i_a_word3),
        .i_b_word0(i_b_word0), .i_b_word1(i_b_word1),
        .i_b_word2(i_b_word2), .i_b_word3(i_b_word3),
        .i_shift_amount(i_shift_amount),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_result_word0(o_result_word0), .o_result_word1(o_result_word1),
        .o_result_word2(o_result_word2), .o_result_word3(o_result_word3)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Random 256-bit value biased toward the corners: all zeros, all ones, words
    // of all ones that ripple carries across words, single set bits, right-shifted values.
    function automatic logic [255:0] pick_operand();
        logic [255:0] v;
        for (int w = 0; w < 8; w++) v[w*32 +: 32] = $urandom;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: begin
                for (int w = 0; w < 4; w++)
                    if ($urandom_range(0, 1)) v[w*64 +: 64] = '1;
            end
            3: v = 256'd1 << $urandom_range(0, 255);
            4: v = v >> $urandom_range(1, 255);
            default: ;
        endcase
        return v;
    endfunction

    // Present one request and hold it until the block accepts it. The
    // scoreboard learns of the request at the accepting edge.
    task automatic send_request(t_mode mode, logic [255:0] a, logic [255:0] b,
                                logic [8:0] amount);
        i_valid        <= 1'b1;
        i_mode         <= mode;
        {i_a_word3, i_a_word2, i_a_word1, i_a_word0} <= a;
        {i_b_word3, i_b_word2, i_b_word1, i_b_word0} <= b;
        i_shift_amount <= amount;
        do @(posedge i_clk); while (!o_ready);
        alu_board.note_request(mode, a, b, amount);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic pause_sender(int unsigned cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Receiver side: results are sampled at the rising edge, and ready is
    // changed only at the falling edge, stalling on its own random pattern.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            alu_board.check_result({o_result_word3, o_result_word2,
                                    o_result_word1, o_result_word0});
    end

    always @(negedge i_clk) begin
        if (!stall_enable)
            i_ready <= 1'b1;
        else
            i_ready <= ($urandom_range(0, 3) != 0);
    end

    // Watchdog: count cycles in which neither channel moves a request or result.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [255:0] a_val, b_val;
        logic [8:0]   amount;
        t_mode        mode;
        int unsigned  burst_left;

        alu_board      = new();
        idle_cycles    = 0;
        requests_sent  = 0;
        stimulus_done  = 1'b0;
        stall_enable   = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b1;
        i_mode         = MODE_ADD;
        {i_a_word3, i_a_word2, i_a_word1, i_a_word0} = '0;
        {i_b_word3, i_b_word2, i_b_word1, i_b_word0} = '0;
        i_shift_amount = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: the carry chain with all-ones words and an incoming
        // carry, borrow through zero, negation of the extremes, products that
        // overflow, shifts at the word boundaries and past the width, and
        // the unused mode codes.
        send_request(MODE_ADD, '1, 256'd1, 9'd0);
        send_request(MODE_ADD, {4{64'hFFFF_FFFF_FFFF_FFFF}}, '1, 9'd511);
        send_request(MODE_ADD, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                64'h1}, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
                                64'hFFFF_FFFF_FFFF_FFFF}, 9'd0);
        send_request(MODE_ADD, '0, '0, 9'd0);
        send_request(MODE_SUB, '0, 256'd1, 9'd0);
        send_request(MODE_SUB, '1, '1, 9'd0);
        send_request(MODE_SUB, 256'd1 << 128, 256'd1, 9'd0);
        send_request(MODE_NEG, '0, '1, 9'd0);
        send_request(MODE_NEG, 256'd1, '0, 9'd0);
        send_request(MODE_NEG, 256'd1 << 255, '0, 9'd0);
        send_request(MODE_MUL, '1, '1, 9'd0);
        send_request(MODE_MUL, '0, '1, 9'd0);
        send_request(MODE_MUL, 256'd1 << 255, 256'd3, 9'd0);
        send_request(MODE_MUL, {64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1},
                     {64'h0, 64'h0, 64'h2, 64'hFFFF_FFFF_FFFF_FFFF}, 9'd0);
        send_request(MODE_SHL, '1, '0, 9'd0);
        send_request(MODE_SHL, '1, '0, 9'd1);
        send_request(MODE_SHL, '1, '0, 9'd64);
        send_request(MODE_SHL, '1, '0, 9'd255);
        send_request(MODE_SHL, '1, '0, 9'd256);
        send_request(MODE_SHL, '1, '1, 9'd511);
        send_request(t_mode'(3'd5), '1, '1, 9'd3);
        send_request(t_mode'(3'd6), '1, '1, 9'd3);
        send_request(t_mode'(3'd7), '1, '1, 9'd3);

        // The sender holds off until every outstanding result has come back.
        pause_sender(1);
        while (alu_board.pending_results.size() != 0) @(negedge i_clk);

        // Random part: bursts of random length, random gaps, receiver stalls.
        stall_enable = 1'b1;
        burst_left   = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                if ($urandom_range(0, 1)) pause_sender($urandom_range(1, 20));
            end
            burst_left--;
            if (n == RANDOM_ITEMS / 2) stall_enable = 1'b0;
            if (n == RANDOM_ITEMS * 3 / 4) stall_enable = 1'b1;
            mode   = t_mode'($urandom_range(0, 15) < 14 ? $urandom_range(0, 4)
                                                         : $urandom_range(5, 7));
            a_val  = pick_operand();
            b_val  = pick_operand();
            // Most shifts stay in range; some go past the width.
            amount = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(256, 511))
                                                 : 9'($urandom_range(0, 256));
            send_request(mode, a_val, b_val, amount);
        end
        pause_sender(1);
        stimulus_done = 1'b1;

        while (alu_board.pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d requests over all five operations, unused codes,",
                 requests_sent);
        $display("carry, borrow and shift-width corners, %0d results checked.",
                 alu_board.checked_count);
        if (alu_board.error_count == 0 && alu_board.pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/wialu_pkg.sv
hw/rtl/wialu_core.sv
hw/rtl/wide_integer_alu_256.sv
bench/tb_wide_integer_alu_256.sv
